// ===== src/vzpc_pkg.sv =====
package vzpc_pkg;

    localparam int EDGE_W    = 13;   // edge and map size width
    localparam int DEG_W     = 5;
    localparam int CTR_W     = 12;
    localparam int FUNC_W    = 3;
    localparam int CALC_W    = 21;   // signed working width, covers zoom-out overshoot
    localparam int CFG_IDX_W = 2;
    localparam int EDGE_MAX  = (1 << EDGE_W) - 1;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd1;

    localparam logic [FUNC_W-1:0] FUNC_FULL     = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ZOOM_IN  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_ZOOM_OUT = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_VCENTER  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_HCENTER  = 3'd4;

    typedef logic signed [CALC_W-1:0] t_calc;
    typedef logic signed [EDGE_W:0]   t_span;
    typedef logic [EDGE_W-1:0]        t_edge;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMD,
        S_SPAN,
        S_DIV,
        S_APPLY,
        S_FIX,
        S_DONE
    } t_state;

    // Halve, truncating toward zero.
    function automatic t_calc half_tz(t_calc x);
        t_calc adj;
        adj = x + t_calc'(x[CALC_W-1]);
        return adj >>> 1;
    endfunction

    function automatic t_edge sat_edge(t_calc x);
        t_edge res;
        if (x < 0) begin
            res = '0;
        end else if (x > t_calc'(EDGE_MAX)) begin
            res = t_edge'(EDGE_MAX);
        end else begin
            res = x[EDGE_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== src/viewport_zoom_pan_clamp.sv =====
// Viewport zoom/pan/clamp. Keeps a rectangle over a map whose height and width are set
// through the config port (saturated to MAX_MAP_DIM) and runs one command per input beat:
// full view, zoom in, zoom out, vertical or horizontal recentre. Each command yields one
// output beat with the new edges and an in-zoom flag; zoom out and recentre pull the
// rectangle back inside the map axis by axis. One command is worked at a time and
// s_axis_tready is high only between commands; a finished result may wait on the output
// register while the next command is taken. Zoom in works each axis through a span
// step, the serial divider (one quotient bit per cycle, 13 bits, run once per axis)
// and an apply step; zoom out works each axis through a multiply and an apply step,
// then four clamp steps through one shared clamp adder; a recentre sets the new edges
// and runs the clamp steps; full view and unused codes go straight to the output.
// A result is also held back while the previous one still waits on the output register.
module viewport_zoom_pan_clamp
    import vzpc_pkg::*;
#(
    parameter int unsigned MAX_MAP_DIM = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [EDGE_W-1:0]    i_cfg_data,
    // command
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,   // zoom_degree[4:0], center_coordinate[16:5]
    input  logic [FUNC_W-1:0]    s_axis_tuser,   // func[2:0]
    // result
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [55:0]          m_axis_tdata    // view_top[12:0], view_bottom[25:13],
                                                 // view_left[38:26], view_right[51:39],
                                                 // in_zoom[52]
);

    t_state            r_state, n_state;
    logic [FUNC_W-1:0] r_func, n_func;
    logic [DEG_W-1:0]  r_deg, n_deg;
    logic [CTR_W-1:0]  r_ctr, n_ctr;
    t_calc             r_t, n_t, r_b, n_b, r_l, n_l, r_r, n_r;
    t_calc             r_delta, n_delta;
    logic              r_neg, n_neg;
    logic              r_axis, n_axis;
    logic [1:0]        r_fix, n_fix;
    t_edge             r_top, n_top, r_bot, n_bot, r_left, n_left, r_right, n_right;
    t_edge             r_map_h, n_map_h, r_map_w, n_map_w;
    logic              r_o_valid, n_o_valid;
    logic [55:0]       r_o_data, n_o_data;

    logic              ax;
    t_calc             ax_lo, ax_hi, ax_size;
    t_calc             fx_lo, fx_hi;
    t_span             span;
    t_edge             span_mag;
    t_calc             prod;
    t_calc             quo_s;
    t_calc             half;
    t_calc             v_half, h_half;
    t_calc             ctr_c;
    t_edge             s_top, s_bot, s_left, s_right;
    logic              zoomed;
    logic              div_start, div_busy, div_done;
    t_edge             div_q;
    t_edge             cfg_sat;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;

    assign cfg_sat = (32'(i_cfg_data) > MAX_MAP_DIM) ? EDGE_W'(MAX_MAP_DIM) : i_cfg_data;

    // axis picked for the shared span/clamp datapath
    assign ax      = (r_state == S_FIX) ? r_fix[1] : r_axis;
    assign ax_lo   = ax ? r_l : r_t;
    assign ax_hi   = ax ? r_r : r_b;
    assign ax_size = t_calc'({1'b0, (ax ? r_map_w : r_map_h)});

    assign span     = t_span'(ax_hi - ax_lo);
    assign span_mag = span[EDGE_W] ? EDGE_W'(-span) : span[EDGE_W-1:0];
    assign prod     = t_calc'(span) * signed'(CALC_W'({1'b0, r_deg}));
    assign quo_s    = r_neg ? -t_calc'({1'b0, div_q}) : t_calc'({1'b0, div_q});
    assign half     = half_tz(r_delta);
    assign v_half   = half_tz(r_b - r_t);
    assign h_half   = half_tz(r_r - r_l);
    assign ctr_c    = t_calc'({1'b0, r_ctr});

    // shared clamp step: low edge check on even steps, high edge check on odd steps
    always_comb begin
        fx_lo = ax_lo;
        fx_hi = ax_hi;
        if (!r_fix[0]) begin
            if (ax_lo < 0) begin
                fx_lo = '0;
                fx_hi = (ax_hi - ax_lo < ax_size) ? ax_hi - ax_lo : ax_size;
            end
        end else begin
            if (ax_hi > ax_size) begin
                fx_hi = ax_size;
                fx_lo = (ax_lo - (ax_hi - ax_size) > 0) ? ax_lo - (ax_hi - ax_size) : '0;
            end
        end
    end

    assign s_top   = sat_edge(r_t);
    assign s_bot   = sat_edge(r_b);
    assign s_left  = sat_edge(r_l);
    assign s_right = sat_edge(r_r);
    assign zoomed  = (s_top != '0) || (s_bot < r_map_h) ||
                     (s_left != '0) || (s_right < r_map_w);

    vzpc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (span_mag),
        .i_divisor  (r_deg),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        n_state   = r_state;
        n_func    = r_func;
        n_deg     = r_deg;
        n_ctr     = r_ctr;
        n_t       = r_t;
        n_b       = r_b;
        n_l       = r_l;
        n_r       = r_r;
        n_delta   = r_delta;
        n_neg     = r_neg;
        n_axis    = r_axis;
        n_fix     = r_fix;
        n_top     = r_top;
        n_bot     = r_bot;
        n_left    = r_left;
        n_right   = r_right;
        n_map_h   = r_map_h;
        n_map_w   = r_map_w;
        n_o_valid = r_o_valid;
        n_o_data  = r_o_data;
        div_start = 1'b0;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MAP_HEIGHT: n_map_h = cfg_sat;
                REG_MAP_WIDTH:  n_map_w = cfg_sat;
                default: ;
            endcase
        end

        if (r_o_valid && m_axis_tready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_func  = s_axis_tuser;
                    n_deg   = (s_axis_tdata[4:0] == '0) ? DEG_W'(1) : s_axis_tdata[4:0];
                    n_ctr   = s_axis_tdata[16:5];
                    n_t     = t_calc'({1'b0, r_top});
                    n_b     = t_calc'({1'b0, r_bot});
                    n_l     = t_calc'({1'b0, r_left});
                    n_r     = t_calc'({1'b0, r_right});
                    n_state = S_CMD;
                end
            end
            S_CMD: begin
                n_axis = 1'b0;
                n_fix  = '0;
                case (r_func)
                    FUNC_FULL: begin
                        n_t     = '0;
                        n_b     = t_calc'({1'b0, r_map_h});
                        n_l     = '0;
                        n_r     = t_calc'({1'b0, r_map_w});
                        n_state = S_DONE;
                    end
                    FUNC_ZOOM_IN, FUNC_ZOOM_OUT: begin
                        n_state = S_SPAN;
                    end
                    FUNC_VCENTER: begin
                        n_t     = ctr_c - v_half;
                        n_b     = ctr_c + v_half;
                        n_state = S_FIX;
                    end
                    FUNC_HCENTER: begin
                        n_l     = ctr_c - h_half;
                        n_r     = ctr_c + h_half;
                        n_state = S_FIX;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SPAN: begin
                if (r_func == FUNC_ZOOM_IN) begin
                    div_start = 1'b1;
                    n_neg     = span[EDGE_W];
                    n_state   = S_DIV;
                end else begin
                    n_delta = prod;
                    n_state = S_APPLY;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_delta = quo_s;
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (r_func == FUNC_ZOOM_IN) begin
                    if (r_axis) begin
                        n_l = r_l + half;
                        n_r = r_r - half;
                    end else begin
                        n_t = r_t + half;
                        n_b = r_b - half;
                    end
                end else begin
                    if (r_axis) begin
                        n_l = r_l - half;
                        n_r = r_r + half;
                    end else begin
                        n_t = r_t - half;
                        n_b = r_b + half;
                    end
                end
                if (!r_axis) begin
                    n_axis  = 1'b1;
                    n_state = S_SPAN;
                end else if (r_func == FUNC_ZOOM_OUT) begin
                    n_state = S_FIX;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FIX: begin
                if (r_fix[1]) begin
                    n_l = fx_lo;
                    n_r = fx_hi;
                end else begin
                    n_t = fx_lo;
                    n_b = fx_hi;
                end
                n_fix = r_fix + 1'b1;
                if (r_fix == 2'd3) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold here while the previous result is still waiting
                if (!r_o_valid || m_axis_tready) begin
                    n_top     = s_top;
                    n_bot     = s_bot;
                    n_left    = s_left;
                    n_right   = s_right;
                    n_o_valid = 1'b1;
                    n_o_data  = {3'b000, zoomed, s_right, s_left, s_bot, s_top};
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_top     <= '0;
            r_bot     <= '0;
            r_left    <= '0;
            r_right   <= '0;
            r_map_h   <= EDGE_W'(1024);
            r_map_w   <= EDGE_W'(1024);
            r_o_valid <= 1'b0;
            r_axis    <= 1'b0;
            r_fix     <= '0;
        end else begin
            r_state   <= n_state;
            r_top     <= n_top;
            r_bot     <= n_bot;
            r_left    <= n_left;
            r_right   <= n_right;
            r_map_h   <= n_map_h;
            r_map_w   <= n_map_w;
            r_o_valid <= n_o_valid;
            r_axis    <= n_axis;
            r_fix     <= n_fix;
        end
        r_func   <= n_func;
        r_deg    <= n_deg;
        r_ctr    <= n_ctr;
        r_t      <= n_t;
        r_b      <= n_b;
        r_l      <= n_l;
        r_r      <= n_r;
        r_delta  <= n_delta;
        r_neg    <= n_neg;
        r_o_data <= n_o_data;
    end

`ifndef SYNTHESIS
    a_div_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> (r_state == S_DIV))
        else $error("divider running outside the divide state");

    a_full_view_edges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_data[52]) |-> (r_o_data[12:0] == '0 && r_o_data[38:26] == '0))
        else $error("in_zoom clear with a nonzero top or left edge");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_CMD))
        else $error("accepted command did not start");
`endif

endmodule

// ===== src/vzpc_div.sv =====
module vzpc_div
    import vzpc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [EDGE_W-1:0] i_dividend,
    input  logic [DEG_W-1:0]  i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output logic [EDGE_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(EDGE_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DEG_W-1:0] r_rem, n_rem;
    logic [EDGE_W-1:0] r_quo, n_quo;
    logic [DEG_W-1:0] r_dvs, n_dvs;
    logic [DEG_W:0]   trial;

    // restoring division, one quotient bit per cycle, MSB first
    assign trial = {r_rem, r_quo[EDGE_W-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = DEG_W'(trial - {1'b0, r_dvs});
                n_quo = {r_quo[EDGE_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DEG_W-1:0];
                n_quo = {r_quo[EDGE_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(EDGE_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
